FILE: hw/rtl/dvc_pkg.sv
// ----------------------------------------------------------------------------
// dvc_pkg
// Shared types, constants and the key compare for the distinct value counter.
// ----------------------------------------------------------------------------
package dvc_pkg;

	localparam int KEY_W          = 32;
	localparam int POS_W          = 7;
	localparam int CNT_OUT_W      = 32;
	localparam int CAPACITY_DEF   = 64;
	localparam int COUNT_BITS_DEF = 32;

	localparam logic [KEY_W-1:0] KEY_MAG_MASK = 32'h7FFF_FFFF;
	localparam logic [KEY_W-1:0] KEY_EXP_MASK = 32'h7F80_0000;
	localparam logic [KEY_W-1:0] KEY_MAN_MASK = 32'h007F_FFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} dvc_state_t;

	function automatic logic key_is_nan(input logic [KEY_W-1:0] k);
		return ((k & KEY_EXP_MASK) == KEY_EXP_MASK) && ((k & KEY_MAN_MASK) != '0);
	endfunction

	// Float equality on raw patterns: NaN never matches, both zeros match.
	function automatic logic keys_equal(input logic [KEY_W-1:0] a,
	                                    input logic [KEY_W-1:0] b);
		logic eq;
		if (key_is_nan(a) || key_is_nan(b)) begin
			eq = 1'b0;
		end else if (((a | b) & KEY_MAG_MASK) == '0) begin
			eq = 1'b1;
		end else begin
			eq = (a == b);
		end
		return eq;
	endfunction

endpackage

FILE: hw/rtl/distinct_value_counter_top.sv
// ----------------------------------------------------------------------------
// distinct_value_counter_top
// Counts occurrences of distinct single-precision keys in a table kept in
// insertion order, with a linear search over a synchronous key memory.
//
//   Channel   Handshake          Payload
//   -------   ----------------   ---------------------------------------------
//   input     start, busy        key_value
//   result    done (one cycle)   entry_position, entry_count, is_new_entry,
//                                was_dropped, entries_in_use
//
// From start, a miss compares every stored key in insertion order, then
// updates and raises done; a hit stops the search at its position.
// The key memory has one read port and delivers one stored key per cycle to
// the compare. A new item may start in the cycle done is high.
// Reset clears the entry count and the control state; the memories need no clearing.
// The receiver cannot stall; each result is marked by done for exactly one cycle.
// ----------------------------------------------------------------------------
module distinct_value_counter_top #(
	parameter int CAPACITY   = dvc_pkg::CAPACITY_DEF,
	parameter int COUNT_BITS = dvc_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [dvc_pkg::KEY_W-1:0]      key_value,
	output logic                           done,
	output logic [dvc_pkg::POS_W-1:0]      entry_position,
	output logic [dvc_pkg::CNT_OUT_W-1:0]  entry_count,
	output logic                           is_new_entry,
	output logic                           was_dropped,
	output logic [dvc_pkg::POS_W-1:0]      entries_in_use
);

	localparam int IDX_W = $clog2(CAPACITY + 1);
	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic [IDX_W-1:0]      CAP_VAL = IDX_W'(CAPACITY);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

	logic [dvc_pkg::KEY_W-1:0] key_mem [CAPACITY];
	logic [COUNT_BITS-1:0]     cnt_mem [CAPACITY];

	dvc_pkg::dvc_state_t state_q, state_nxt;

	logic [dvc_pkg::KEY_W-1:0] key_q;
	logic [IDX_W-1:0]          used_q;
	logic [IDX_W-1:0]          rd_idx_q;

	logic                      cmp_vld_s1;
	logic [AW-1:0]             cmp_idx_s1;
	logic [dvc_pkg::KEY_W-1:0] key_rd_s1;
	logic [COUNT_BITS-1:0]     cnt_rd_s1;

	logic                      hit_q;
	logic [AW-1:0]             hit_idx_q;
	logic [COUNT_BITS-1:0]     hit_cnt_q;

	logic                      accept;
	logic                      rd_en;
	logic                      match;
	logic                      scan_hit;
	logic                      scan_miss;

	logic                      upd_key_we;
	logic                      upd_cnt_we;
	logic [AW-1:0]             upd_addr;
	logic [COUNT_BITS-1:0]     upd_cnt;
	logic [IDX_W-1:0]          upd_pos;
	logic                      upd_fresh;
	logic                      upd_drop;

	logic                      done_q;
	logic [dvc_pkg::POS_W-1:0] pos_q;
	logic [dvc_pkg::CNT_OUT_W-1:0] cnt_out_q;
	logic                      fresh_q;
	logic                      drop_q;
	logic [dvc_pkg::POS_W-1:0] in_use_q;

	// ------------------------------------------------------------------------
	// Control
	// ------------------------------------------------------------------------
	always_comb begin
		accept    = start && (state_q == dvc_pkg::ST_IDLE);
		rd_en     = (state_q == dvc_pkg::ST_SCAN) && (rd_idx_q < used_q);
		match     = cmp_vld_s1 && dvc_pkg::keys_equal(key_q, key_rd_s1);
		scan_hit  = (state_q == dvc_pkg::ST_SCAN) && match;
		// The last stored key has been compared without a match.
		scan_miss = (state_q == dvc_pkg::ST_SCAN) && !match && (rd_idx_q >= used_q);
		busy      = (state_q != dvc_pkg::ST_IDLE);

		state_nxt = state_q;
		case (state_q)
			dvc_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = dvc_pkg::ST_SCAN;
				end
			end
			dvc_pkg::ST_SCAN: begin
				if (scan_hit || scan_miss) begin
					state_nxt = dvc_pkg::ST_UPDATE;
				end
			end
			dvc_pkg::ST_UPDATE: begin
				state_nxt = dvc_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = dvc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// ------------------------------------------------------------------------
	// Search: one stored key read per cycle, registered and compared later
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			// A hit ends the search, so a read still in flight is discarded.
			cmp_vld_s1 <= rd_en && !scan_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			key_rd_s1  <= key_mem[rd_idx_q[AW-1:0]];
			cnt_rd_s1  <= cnt_mem[rd_idx_q[AW-1:0]];
			cmp_idx_s1 <= rd_idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (scan_hit || scan_miss) begin
			hit_q     <= scan_hit;
			hit_idx_q <= cmp_idx_s1;
			hit_cnt_q <= cnt_rd_s1;
		end
	end

	// ------------------------------------------------------------------------
	// Update: bump the hit entry, or append the new key if there is room, else drop the key
	// ------------------------------------------------------------------------
	always_comb begin
		upd_key_we = 1'b0;
		upd_cnt_we = 1'b0;
		upd_addr   = hit_idx_q;
		upd_cnt    = '0;
		upd_pos    = '0;
		upd_fresh  = 1'b0;
		upd_drop   = 1'b0;
		if (state_q == dvc_pkg::ST_UPDATE) begin
			if (hit_q) begin
				upd_cnt_we = 1'b1;
				upd_cnt    = (hit_cnt_q == CNT_MAX) ? hit_cnt_q
				                                    : hit_cnt_q + CNT_ONE;
				upd_pos    = IDX_W'(hit_idx_q) + IDX_W'(1);
			end else if (used_q < CAP_VAL) begin
				upd_key_we = 1'b1;
				upd_cnt_we = 1'b1;
				upd_addr   = used_q[AW-1:0];
				upd_cnt    = CNT_ONE;
				upd_pos    = used_q + IDX_W'(1);
				upd_fresh  = 1'b1;
			end else begin
				upd_drop   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_key_we) begin
			key_mem[upd_addr] <= key_q;
		end
		if (upd_cnt_we) begin
			cnt_mem[upd_addr] <= upd_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (upd_fresh) begin
				used_q <= used_q + IDX_W'(1);
			end
			done_q <= (state_q == dvc_pkg::ST_UPDATE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dvc_pkg::ST_UPDATE) begin
			pos_q     <= dvc_pkg::POS_W'(upd_pos);
			cnt_out_q <= dvc_pkg::CNT_OUT_W'(upd_cnt);
			fresh_q   <= upd_fresh;
			drop_q    <= upd_drop;
			in_use_q  <= upd_fresh ? dvc_pkg::POS_W'(upd_pos) : dvc_pkg::POS_W'(used_q);
		end
	end

	assign done           = done_q;
	assign entry_position = pos_q;
	assign entry_count    = cnt_out_q;
	assign is_new_entry   = fresh_q;
	assign was_dropped    = drop_q;
	assign entries_in_use = in_use_q;

endmodule
